FILE: hw/rtl/cgc_pkg.sv
package cgc_pkg;

  // Index fields (token, register values, class position) are fixed at 12 bits.
  localparam int IDX_W = 12;

  localparam int MAX_CLASSES = 4096;

  // Highest class position a frame may use; larger blank settings are clamped here.
  localparam int BLANK_CAP_INT =
      ((MAX_CLASSES - 1) < ((1 << IDX_W) - 1)) ? (MAX_CLASSES - 1) : ((1 << IDX_W) - 1);
  localparam logic [IDX_W-1:0] BLANK_CAP = IDX_W'(BLANK_CAP_INT);

  localparam int PROB_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam logic [IDX_W-1:0] BLANK_RST = IDX_W'(28);
  localparam logic [IDX_W-1:0] SPACE_RST = IDX_W'(0);

  // configuration register indexes
  typedef enum logic {
    REG_BLANK_INDEX = 1'b0,
    REG_SPACE_INDEX = 1'b1
  } cfg_reg_t;

endpackage

FILE: hw/rtl/cgc_skid.sv
module cgc_skid #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  logic [DATA_W-1:0] skid_data_r, skid_data_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        // spare entry drains first; no push can arrive while it is full
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("spare entry full while output empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && out_data_r == $past(out_data_r))
    else $error("stalled result lost or changed");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed into full output stage");

endmodule

FILE: hw/rtl/ctc_greedy_collapse.sv
// Streaming CTC greedy (best-path) collapse.
// in_*  : one class probability per beat, class 0 first; a frame is blank_index+1
//         beats. in_end_of_sequence marks the last beat of an utterance.
// out_* : one beat per emitted token: class index, frame number (saturating) and
//         a space flag. Blanks and repeats of the previous frame's argmax are dropped.
// cfg_* : write-only registers, index 0 blank_index, index 1 space_index; write
//         only while the block is idle.
// Throughput: one input beat per cycle while in_ready is high. The argmax compare/select and the frame-end
// decision are a single stage feeding the output register, so a token is registered on out_*
// after the last beat of its frame, or into the spare while out_* is stalled.
// Stall: the output register has a one-entry spare behind it; in_ready drops only
// while that spare holds a result, so up to two results are buffered.
// Reset (rst_n low, synchronous): registers to blank 28 / space 0, argmax, class
// position, frame counter and history cleared, output empty. No clearing pass.
module ctc_greedy_collapse
  import cgc_pkg::*;
#(
  parameter int PROB_BITS = PROB_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PROB_BITS-1:0] in_prob,
  input  logic                 in_end_of_sequence,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_token,
  output logic [TIME_BITS-1:0] out_time_step,
  output logic                 out_is_space,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [IDX_W-1:0]     cfg_data
);

  localparam int   RES_W = IDX_W + TIME_BITS + 1;

  logic [IDX_W-1:0]     blank_index_r, space_index_r;
  logic [PROB_BITS-1:0] best_value_r, best_value_nxt;
  logic [IDX_W-1:0]     best_class_r, best_class_nxt;
  logic [IDX_W-1:0]     class_counter_r, class_counter_nxt;
  logic [IDX_W-1:0]     previous_class_r, previous_class_nxt;
  logic                 previous_valid_r, previous_valid_nxt;
  logic [TIME_BITS-1:0] frame_counter_r, frame_counter_nxt;

  logic                 in_fire;
  logic [IDX_W-1:0]     blank_lim;
  logic                 prob_gt;
  logic [PROB_BITS-1:0] lead_value;
  logic [IDX_W-1:0]     lead_class;
  logic                 frame_end;
  logic                 emit;
  logic [RES_W-1:0]     res_data, out_data;

  assign in_fire   = in_valid && in_ready;
  assign blank_lim = (blank_index_r > BLANK_CAP) ? BLANK_CAP : blank_index_r;
  // strict compare: the earliest class keeps ties
  assign prob_gt    = in_prob > best_value_r;
  assign lead_value = prob_gt ? in_prob : best_value_r;
  assign lead_class = prob_gt ? class_counter_r : best_class_r;
  assign frame_end  = class_counter_r >= blank_lim;
  assign emit = in_fire && frame_end && (lead_class != blank_lim) &&
                !(previous_valid_r && (lead_class == previous_class_r));
  assign res_data = {lead_class, frame_counter_r, (lead_class == space_index_r)};

  always_comb begin
    best_value_nxt     = best_value_r;
    best_class_nxt     = best_class_r;
    class_counter_nxt  = class_counter_r;
    previous_class_nxt = previous_class_r;
    previous_valid_nxt = previous_valid_r;
    frame_counter_nxt  = frame_counter_r;
    if (in_fire) begin
      if (frame_end) begin
        previous_class_nxt = lead_class;
        previous_valid_nxt = 1'b1;
        if (frame_counter_r != {TIME_BITS{1'b1}}) begin
          frame_counter_nxt = frame_counter_r + 1'b1;
        end
        best_value_nxt    = '0;
        best_class_nxt    = '0;
        class_counter_nxt = '0;
      end else begin
        best_value_nxt    = lead_value;
        best_class_nxt    = lead_class;
        class_counter_nxt = class_counter_r + 1'b1;
      end
      // end of sequence drops any partial frame and the history
      if (in_end_of_sequence) begin
        best_value_nxt     = '0;
        best_class_nxt     = '0;
        class_counter_nxt  = '0;
        previous_class_nxt = '0;
        previous_valid_nxt = 1'b0;
        frame_counter_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_index_r    <= BLANK_RST;
      space_index_r    <= SPACE_RST;
      best_value_r     <= '0;
      best_class_r     <= '0;
      class_counter_r  <= '0;
      previous_class_r <= '0;
      previous_valid_r <= 1'b0;
      frame_counter_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BLANK_INDEX: blank_index_r <= cfg_data;
          REG_SPACE_INDEX: space_index_r <= cfg_data;
          default: ;
        endcase
      end
      best_value_r     <= best_value_nxt;
      best_class_r     <= best_class_nxt;
      class_counter_r  <= class_counter_nxt;
      previous_class_r <= previous_class_nxt;
      previous_valid_r <= previous_valid_nxt;
      frame_counter_r  <= frame_counter_nxt;
    end
  end

  cgc_skid #(
    .DATA_W(RES_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (emit),
    .push_data(res_data),
    .can_push (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_token     = out_data[RES_W-1 -: IDX_W];
  assign out_time_step = out_data[TIME_BITS:1];
  assign out_is_space  = out_data[0];

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_sequence |=>
      !previous_valid_r && frame_counter_r == '0 && class_counter_r == '0)
    else $error("end of sequence did not clear history");

  a_frame_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    class_counter_r == '0 |-> best_value_r == '0 && best_class_r == '0)
    else $error("argmax not cleared at frame start");

  a_leader_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    class_counter_r != '0 |-> best_class_r < class_counter_r)
    else $error("argmax class ahead of frame position");

  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_end_of_sequence |=> frame_counter_r >= $past(frame_counter_r))
    else $error("frame counter went backwards");

endmodule

FILE: bench/ctc_greedy_collapse_test.sv
`timescale 1ns / 100ps

module ctc_greedy_collapse_test
  import cgc_pkg::*;
();

  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [IDX_W-1:0] token;
    logic [15:0]      time_step;
    logic             is_space;
  } token_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [15:0]      in_prob;
  logic             in_end_of_sequence;
  logic             out_valid;
  logic             out_ready;
  logic [IDX_W-1:0] out_token;
  logic [15:0]      out_time_step;
  logic             out_is_space;
  logic             cfg_wr_en;
  logic             cfg_index;
  logic [IDX_W-1:0] cfg_data;

  ctc_greedy_collapse u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_prob            (in_prob),
    .in_end_of_sequence (in_end_of_sequence),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_token          (out_token),
    .out_time_step      (out_time_step),
    .out_is_space       (out_is_space),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // decoder copy: registers and per-frame / per-sequence state
  logic [IDX_W-1:0] blank_reg = BLANK_RST;
  logic [IDX_W-1:0] space_reg = SPACE_RST;
  logic [15:0]      lead_prob = '0;
  logic [IDX_W-1:0] lead_cls  = '0;
  logic [IDX_W-1:0] pos       = '0;
  logic [IDX_W-1:0] hist_cls  = '0;
  logic             hist_ok   = 1'b0;
  logic [15:0]      frame_no  = '0;

  token_t token_q[$];
  token_t want;
  int     n_err         = 0;
  int     in_gap_max    = 15;
  int     out_stall_max = 15;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void collapse_step(input logic [15:0] p, input logic eos);
    logic [IDX_W-1:0] lim;
    logic [IDX_W-1:0] cls;
    token_t           tok;
    lim = (blank_reg > BLANK_CAP) ? BLANK_CAP : blank_reg;
    if (p > lead_prob) begin
      lead_prob = p;
      lead_cls  = pos;
    end
    if (pos >= lim) begin
      cls = lead_cls;
      if (!(hist_ok && cls == hist_cls) && cls != lim) begin
        tok.token     = cls;
        tok.time_step = frame_no;
        tok.is_space  = (cls == space_reg);
        token_q.insert(token_q.size(), tok);
      end
      hist_cls = cls;
      hist_ok  = 1'b1;
      if (frame_no != '1) frame_no++;
      lead_prob = '0;
      lead_cls  = '0;
      pos       = '0;
    end else begin
      pos = pos + 1'b1;
    end
    if (eos) begin
      lead_prob = '0;
      lead_cls  = '0;
      pos       = '0;
      hist_cls  = '0;
      hist_ok   = 1'b0;
      frame_no  = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) collapse_step(in_prob, in_end_of_sequence);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $error("token beat with nothing expected: token %0d time_step %0d",
               out_token, out_time_step);
        n_err++;
      end else begin
        want = token_q.pop_front();
        if (out_token !== want.token) begin
          $error("token: expected %0d, got %0d", want.token, out_token);
          n_err++;
        end
        if (out_time_step !== want.time_step) begin
          $error("time_step: expected %0d, got %0d", want.time_step, out_time_step);
          n_err++;
        end
        if (out_is_space !== want.is_space) begin
          $error("is_space: expected %0d, got %0d", want.is_space, out_is_space);
          n_err++;
        end
      end
    end
  end

  // result side backpressure
  initial begin : ready_drive
    int stall;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // valid stays up across back-to-back beats; it only drops for a gap
  task automatic send_prob(input logic [15:0] p, input logic eos);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_prob            <= p;
    in_end_of_sequence <= eos;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame3(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c, input logic eos);
    send_prob(a, 1'b0);
    send_prob(b, 1'b0);
    send_prob(c, eos);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [IDX_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_BLANK_INDEX) blank_reg = val;
    else space_reg = val;
    @(posedge clk);
  endtask

  function automatic logic [15:0] draw_prob();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  // reset values: 29-class frame, space is class 0
  task automatic test_reset_defaults();
    for (int k = 0; k < 29; k++) begin
      if (k == 0 || k == 17) send_prob(16'h8000, 1'b0);
      else send_prob(16'($urandom_range(0, 16'h7FFF)), 1'b0);
    end
  endtask

  task automatic test_frame_rules();
    drain_results();
    write_reg(REG_BLANK_INDEX, 12'd2);
    write_reg(REG_SPACE_INDEX, 12'd1);
    send_frame3(16'h0000, 16'h0000, 16'h0000, 1'b0);  // all zero -> class 0
    send_frame3(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);  // tie, lower index wins
    send_frame3(16'h0005, 16'h0005, 16'h0009, 1'b0);  // blank dropped
    send_frame3(16'h0000, 16'hFFFF, 16'h0000, 1'b0);  // same token across a blank
    send_frame3(16'h0000, 16'h0007, 16'h0001, 1'b0);  // repeat dropped
    send_frame3(16'h0009, 16'h0000, 16'h0000, 1'b1);  // end of sequence on last beat
    send_frame3(16'h0008, 16'h0000, 16'h0000, 1'b0);  // history gone, time back to 0
    send_prob(16'h0000, 1'b0);
    send_prob(16'h0009, 1'b1);                         // partial frame thrown away
    send_frame3(16'h0003, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_blank_lowered();
    drain_results();
    write_reg(REG_BLANK_INDEX, 12'd10);
    write_reg(REG_SPACE_INDEX, 12'd4);
    for (int k = 0; k < 6; k++) send_prob((k == 4) ? 16'h4000 : 16'h0100, 1'b0);
    drain_results();
    write_reg(REG_BLANK_INDEX, 12'd3);
    send_prob(16'h0200, 1'b0);  // position already past the new blank
    for (int k = 0; k < 4; k++) send_prob((k == 2) ? 16'h7777 : 16'h0010, 1'b0);
  endtask

  // longest frame setting: a partial frame, then dropped by end of sequence
  task automatic test_blank_max();
    drain_results();
    write_reg(REG_BLANK_INDEX, 12'hFFF);
    write_reg(REG_SPACE_INDEX, 12'hFFE);
    for (int k = 0; k < 24; k++)
      send_prob((k == 20) ? 16'hFFFF : 16'($urandom_range(0, 16'h7FFF)), k == 23);
  endtask

  task automatic test_time_steps();
    drain_results();
    write_reg(REG_BLANK_INDEX, 12'd0);  // one-beat frames, all blank
    in_gap_max = 0;
    for (int k = 0; k < 20; k++) send_prob(16'($urandom), 1'b0);
    drain_results();
    in_gap_max = 15;
    write_reg(REG_BLANK_INDEX, 12'd2);
    write_reg(REG_SPACE_INDEX, 12'd1);
    for (int f = 0; f < 6; f++) begin
      if (f % 2 == 0) send_frame3(16'h0100, 16'h0005, 16'h0000, f == 5);
      else send_frame3(16'h0005, 16'h0100, 16'h0000, f == 5);
    end
    send_frame3(16'h0000, 16'h0100, 16'h0000, 1'b0);
  endtask

  task automatic test_random_streams();
    int               sent;
    int               k;
    logic             eos_bit;
    logic [IDX_W-1:0] b;
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      b = IDX_W'($urandom_range(1, 6));
      write_reg(REG_BLANK_INDEX, b);
      if ($urandom_range(0, 1)) write_reg(REG_SPACE_INDEX, IDX_W'($urandom_range(0, b)));
      else write_reg(REG_SPACE_INDEX, IDX_W'($urandom));
      in_gap_max    = (ph % 3 == 2) ? 0 : 15;
      out_stall_max = (ph % 4 == 1) ? 0 : 15;
      sent = 0;
      while (sent < 32) begin
        k = 0;
        while (k <= b) begin
          if (k < b && $urandom_range(0, 49) == 0) eos_bit = 1'b1;
          else eos_bit = (k == b) && ($urandom_range(0, 5) == 0);
          send_prob(draw_prob(), eos_bit);
          sent++;
          k = eos_bit ? b + 1 : k + 1;
        end
      end
      // sometimes leave a frame open across the next register change
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, b)) begin
          send_prob(draw_prob(), 1'b0);
        end
      end
    end
    in_gap_max    = 15;
    out_stall_max = 15;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_prob            <= '0;
    in_end_of_sequence <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= REG_BLANK_INDEX;
    cfg_data           <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_frame_rules();
    test_blank_lowered();
    test_blank_max();
    test_time_steps();
    test_random_streams();
    drain_results();

    if (n_err == 0) $display("[ctc_greedy_collapse] OK");
    else $display("[ctc_greedy_collapse] ERROR");
    $finish;
  end

  initial begin
    #(64'd12_000_000);
    $display("[ctc_greedy_collapse] ERROR");
    $finish;
  end

endmodule
